@@ src/utf8d_pkg.sv @@
`default_nettype none

package utf8d_pkg;

   localparam int CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] REG_REJECT_OVERLONG     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_REJECT_SURROGATE    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_REJECT_OUT_OF_RANGE = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_REJECT_NONCHAR      = 2'd3;

   localparam logic [20:0] CP_REPLACEMENT = 21'h00FFFD;
   localparam logic [20:0] CP_MIN_2BYTE   = 21'h000080;
   localparam logic [20:0] CP_MIN_3BYTE   = 21'h000800;
   localparam logic [20:0] CP_MIN_4BYTE   = 21'h010000;
   localparam logic [20:0] CP_SURR_LO     = 21'h00D800;
   localparam logic [20:0] CP_SURR_HI     = 21'h00DFFF;
   localparam logic [20:0] CP_MAX         = 21'h10FFFF;
   localparam logic [20:0] CP_NONCHAR_LO  = 21'h00FDD0;
   localparam logic [20:0] CP_NONCHAR_HI  = 21'h00FDEF;

   localparam logic [7:0] CONT_MASK  = 8'hC0;
   localparam logic [7:0] CONT_MATCH = 8'h80;

   typedef logic [3:0][7:0] byte_vec_type;

   typedef struct packed {
      logic reject_overlong;
      logic reject_surrogate;
      logic reject_out_of_range;
      logic reject_nonchar;
   } cfg_type;

   typedef struct packed {
      logic        emit;
      logic        fail;
      logic [2:0]  adv;
      logic [20:0] cp;
   } step_type;

   function automatic logic is_cont(input logic [7:0] b);
      return (b & CONT_MASK) == CONT_MATCH;
   endfunction

   function automatic logic [2:0] seq_len(input logic [7:0] b);
      logic [2:0] n;
      if (b[7] == 1'b0) n = 3'd1;
      else if (b[7:5] == 3'b110) n = 3'd2;
      else if (b[7:4] == 4'b1110) n = 3'd3;
      else if (b[7:3] == 5'b11110) n = 3'd4;
      else n = 3'd0;
      return n;
   endfunction

   // Bad continuation bytes within the available part of the sequence.
   function automatic logic prefix_bad(input byte_vec_type b, input logic [2:0] avail,
                                       input logic [2:0] need);
      logic bad;
      bad = 1'b0;
      for (int k = 1; k < 4; k++) begin
         if (3'(k) < avail && 3'(k) < need && !is_cont(b[k])) bad = 1'b1;
      end
      return bad;
   endfunction

   function automatic step_type eval_step(input byte_vec_type b, input logic [2:0] avail,
                                          input logic last, input cfg_type cfg);
      logic [2:0]  need;
      logic        fail;
      logic        rej;
      logic [20:0] cp;
      step_type    r;
      need   = seq_len(b[0]);
      fail   = 1'b0;
      rej    = 1'b0;
      r.emit = 1'b1;
      if (need == 3'd0) begin
         fail = 1'b1;
      end else begin
         fail = prefix_bad(b, avail, need);
         if (!fail && avail < need) begin
            if (!last) r.emit = 1'b0;
            else fail = 1'b1;
         end
      end
      unique case (need)
         3'd1: cp = {13'd0, b[0]};
         3'd2: cp = {10'd0, b[0][4:0], b[1][5:0]};
         3'd3: cp = {5'd0, b[0][3:0], b[1][5:0], b[2][5:0]};
         default: cp = {b[0][2:0], b[1][5:0], b[2][5:0], b[3][5:0]};
      endcase
      if (cfg.reject_overlong) begin
         if (need == 3'd2 && cp < CP_MIN_2BYTE) rej = 1'b1;
         if (need == 3'd3 && cp < CP_MIN_3BYTE) rej = 1'b1;
         if (need == 3'd4 && cp < CP_MIN_4BYTE) rej = 1'b1;
      end
      if (cfg.reject_surrogate && need == 3'd3 && cp >= CP_SURR_LO && cp <= CP_SURR_HI)
         rej = 1'b1;
      if (cfg.reject_out_of_range && cp > CP_MAX) rej = 1'b1;
      if (cfg.reject_nonchar) begin
         if (cp >= CP_NONCHAR_LO && cp <= CP_NONCHAR_HI) rej = 1'b1;
         if (cp[15:1] == 15'h7FFF && cp <= CP_MAX) rej = 1'b1;
      end
      r.fail = fail || rej;
      r.cp   = r.fail ? CP_REPLACEMENT : cp;
      r.adv  = r.fail ? 3'd1 : need;
      return r;
   endfunction

   // True when the bytes left give no further word for this input byte.
   function automatic logic stops(input byte_vec_type b, input logic [2:0] avail,
                                  input logic last);
      logic [2:0] need;
      logic       s;
      need = seq_len(b[0]);
      if (avail == 3'd0) s = 1'b1;
      else if (need == 3'd0) s = 1'b0;
      else if (prefix_bad(b, avail, need)) s = 1'b0;
      else s = (avail < need) && !last;
      return s;
   endfunction

endpackage

`default_nettype wire

@@ src/utf8_validating_decoder_unit.sv @@
`default_nettype none

// An accepted input word moves the block from idle to its run state, where each result word is registered.
// The single decode-step unit resolves one sequence per cycle while the output is not stalled, giving up to
// four results per input word; the block takes no new input word until it returns to idle.
// An input word that only extends an unfinished sequence yields no result and returns the block to idle.
// Synchronous active-high reset clears the held byte count and the result valid flag, returns to idle and
// sets all reject controls to 1.
module utf8_validating_decoder_unit (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_tvalid,
   output logic                                        req_tready,
   input  wire logic [7:0]                             req_tdata,  // in_byte
   input  wire logic                                   req_tlast,
   output logic                                        rsp_tvalid,
   input  wire logic                                   rsp_tready,
   output logic [23:0]                                 rsp_tdata,  // code_point, zero fill
   output logic                                        rsp_tuser,  // malformed
   output logic                                        rsp_tlast,
   input  wire logic                                   csr_we,
   input  wire logic [utf8d_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic                                   csr_wdata
);
   import utf8d_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   logic         state_ff, state_in;
   byte_vec_type buf_ff, buf_in;
   logic [2:0]   count_ff, count_in;
   logic         strm_last_ff, strm_last_in;
   cfg_type      cfg_ff, cfg_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [20:0]  rsp_cp_ff, rsp_cp_in;
   logic         rsp_mal_ff, rsp_mal_in;
   logic         rsp_last_ff, rsp_last_in;

   step_type     step;
   byte_vec_type shifted;
   logic [2:0]   remain;
   logic         run_last;
   logic         can_step;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'd0, rsp_cp_ff};
   assign rsp_tuser  = rsp_mal_ff;
   assign rsp_tlast  = rsp_last_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_REJECT_OVERLONG:     cfg_in.reject_overlong     = csr_wdata;
            REG_REJECT_SURROGATE:    cfg_in.reject_surrogate    = csr_wdata;
            REG_REJECT_OUT_OF_RANGE: cfg_in.reject_out_of_range = csr_wdata;
            REG_REJECT_NONCHAR:      cfg_in.reject_nonchar      = csr_wdata;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      step     = eval_step(buf_ff, count_ff, strm_last_ff, cfg_ff);
      shifted  = byte_vec_type'(buf_ff >> {step.adv, 3'b000});
      remain   = count_ff - step.adv;
      run_last = stops(shifted, remain, strm_last_ff);
      can_step = !rsp_valid_ff || rsp_tready;

      state_in     = state_ff;
      buf_in       = buf_ff;
      count_in     = count_ff;
      strm_last_in = strm_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_cp_in    = rsp_cp_ff;
      rsp_mal_in   = rsp_mal_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               for (int i = 0; i < 4; i++) begin
                  if (count_ff[1:0] == 2'(i)) buf_in[i] = req_tdata;
               end
               count_in     = count_ff + 3'd1;
               strm_last_in = req_tlast;
               state_in     = ST_RUN;
            end
         end
         ST_RUN: begin
            if (can_step) begin
               if (step.emit) begin
                  rsp_valid_in = 1'b1;
                  rsp_cp_in    = step.cp;
                  rsp_mal_in   = step.fail;
                  rsp_last_in  = run_last;
                  buf_in       = shifted;
                  count_in     = remain;
                  if (run_last) state_in = ST_IDLE;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= 3'd0;
         rsp_valid_ff <= 1'b0;
         cfg_ff       <= '{1'b1, 1'b1, 1'b1, 1'b1};
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff       <= buf_in;
      strm_last_ff <= strm_last_in;
      rsp_cp_ff    <= rsp_cp_in;
      rsp_mal_ff   <= rsp_mal_in;
      rsp_last_ff  <= rsp_last_in;
   end

   a_run_has_bytes: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RUN |-> count_ff != 3'd0)
      else $error("decoder running with no bytes held");

   a_idle_holds_at_most_three: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> count_ff <= 3'd3)
      else $error("more than three bytes held while idle");

   a_malformed_is_replacement: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_mal_ff |-> rsp_cp_ff == CP_REPLACEMENT)
      else $error("malformed word without replacement code point");

   a_accept_starts_run: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> state_ff == ST_RUN)
      else $error("accepted byte did not start a decode run");

endmodule

`default_nettype wire

@@ dv/utf8_decode_scoreboard_pkg.sv @@
package utf8_decode_scoreboard_pkg;

   import utf8d_pkg::*;

   typedef struct packed {
      logic [20:0] code_point;
      logic        malformed;
      logic        run_last;
   } decoded_word_type;

   class utf8_decode_scoreboard;
      bit                reject_overlong;
      bit                reject_surrogate;
      bit                reject_out_of_range;
      bit                reject_nonchar;
      logic [2:0][7:0]   held_bytes;
      int unsigned       held_count;
      decoded_word_type  expected_words[$];
      int unsigned       mismatches;
      int unsigned       bytes_seen;
      int unsigned       words_seen;
      int unsigned       malformed_seen;

      function new();
         reject_overlong     = 1'b1;
         reject_surrogate    = 1'b1;
         reject_out_of_range = 1'b1;
         reject_nonchar      = 1'b1;
         held_bytes          = '0;
         held_count          = 0;
         mismatches          = 0;
         bytes_seen          = 0;
         words_seen          = 0;
         malformed_seen      = 0;
      endfunction

      function void write_register(input logic [CSR_INDEX_W-1:0] index, input logic value);
         case (index)
            REG_REJECT_OVERLONG:     reject_overlong     = value;
            REG_REJECT_SURROGATE:    reject_surrogate    = value;
            REG_REJECT_OUT_OF_RANGE: reject_out_of_range = value;
            REG_REJECT_NONCHAR:      reject_nonchar      = value;
            default: ;
         endcase
      endfunction

      function int unsigned lead_length(input logic [7:0] b);
         if (b[7] == 1'b0) return 1;
         if (b[7:5] == 3'b110) return 2;
         if (b[7:4] == 4'b1110) return 3;
         if (b[7:3] == 5'b11110) return 4;
         return 0;
      endfunction

      function bit is_continuation(input logic [7:0] b);
         return b[7:6] == 2'b10;
      endfunction

      function bit is_noncharacter(input logic [20:0] value);
         if (value >= CP_NONCHAR_LO && value <= CP_NONCHAR_HI) return 1'b1;
         return value[15:1] == 15'h7FFF && value <= CP_MAX;
      endfunction

      // Returns 0 when one of the enabled rules rejects the sequence.
      function bit decode_sequence(input logic [3:0][7:0] seq, input int unsigned len,
                                   output logic [20:0] value);
         bit ok;
         ok = 1'b1;
         case (len)
            1: value = {13'd0, seq[0]};
            2: begin
               value = {10'd0, seq[0][4:0], seq[1][5:0]};
               if (reject_overlong && value < CP_MIN_2BYTE) ok = 1'b0;
            end
            3: begin
               value = {5'd0, seq[0][3:0], seq[1][5:0], seq[2][5:0]};
               if (reject_overlong && value < CP_MIN_3BYTE) ok = 1'b0;
               if (reject_surrogate && value >= CP_SURR_LO && value <= CP_SURR_HI) ok = 1'b0;
            end
            default: begin
               value = {seq[0][2:0], seq[1][5:0], seq[2][5:0], seq[3][5:0]};
               if (reject_overlong && value < CP_MIN_4BYTE) ok = 1'b0;
            end
         endcase
         if (reject_out_of_range && value > CP_MAX) ok = 1'b0;
         if (reject_nonchar && is_noncharacter(value)) ok = 1'b0;
         return ok;
      endfunction

      function void note_byte(input logic [7:0] data, input logic last);
         logic [3:0][7:0]  window;
         logic [3:0][7:0]  aligned;
         logic [20:0]      value;
         decoded_word_type produced[$];
         decoded_word_type word;
         int unsigned      total;
         int unsigned      pos;
         int unsigned      need;
         int unsigned      avail;
         int unsigned      upto;
         int unsigned      k;
         bit               fail;
         window = '0;
         for (k = 0; k < held_count; k++) window[k] = held_bytes[k];
         window[held_count] = data;
         total = held_count + 1;
         pos = 0;
         while (pos < total) begin
            need  = lead_length(window[pos]);
            avail = total - pos;
            fail  = 1'b0;
            value = '0;
            if (need == 0) begin
               fail = 1'b1;
            end else begin
               upto = (avail < need) ? avail : need;
               for (k = 1; k < upto; k++) begin
                  if (!is_continuation(window[pos + k])) fail = 1'b1;
               end
               if (!fail && avail < need) begin
                  if (!last) break;
                  fail = 1'b1;
               end
               aligned = window >> (8 * pos);
               if (!fail && !decode_sequence(aligned, need, value)) fail = 1'b1;
            end
            if (fail) begin
               word = '{code_point: CP_REPLACEMENT, malformed: 1'b1, run_last: 1'b0};
               pos += 1;
            end else begin
               word = '{code_point: value, malformed: 1'b0, run_last: 1'b0};
               pos += need;
            end
            produced.push_back(word);
         end
         held_count = total - pos;
         for (k = 0; k < 3; k++) held_bytes[k] = (k < held_count) ? window[pos + k] : 8'h00;
         for (k = 0; k < produced.size(); k++) begin
            word = produced[k];
            word.run_last = (k == produced.size() - 1);
            expected_words.push_back(word);
         end
         bytes_seen++;
      endfunction

      function void check_word(input logic [20:0] code_point, input logic malformed,
                               input logic run_last);
         decoded_word_type want;
         words_seen++;
         if (malformed) malformed_seen++;
         if (expected_words.size() == 0) begin
            $error("unexpected word: code_point %h malformed %b run_last %b",
                   code_point, malformed, run_last);
            mismatches++;
            return;
         end
         want = expected_words.pop_front();
         if (want.code_point !== code_point) begin
            $error("code_point: expected %h, actual %h", want.code_point, code_point);
            mismatches++;
         end
         if (want.malformed !== malformed) begin
            $error("malformed: expected %b, actual %b", want.malformed, malformed);
            mismatches++;
         end
         if (want.run_last !== run_last) begin
            $error("run_last: expected %b, actual %b", want.run_last, run_last);
            mismatches++;
         end
      endfunction

      function int unsigned outstanding();
         return expected_words.size();
      endfunction
   endclass

endpackage

@@ dv/tb.sv @@
module tb;

   import utf8d_pkg::*;
   import utf8_decode_scoreboard_pkg::*;

   localparam int unsigned CYCLE_LIMIT    = 200000;
   localparam int unsigned SETTLE_CYCLES  = 12;
   localparam int unsigned HOLD_CYCLES    = 120;
   localparam int unsigned BYTES_PER_PASS = 66;
   localparam int unsigned PASS_COUNT     = 6;

   typedef enum {
      READY_ALWAYS,
      READY_MOSTLY,
      READY_RARELY,
      READY_PATTERN
   } ready_style_type;

   typedef enum {
      SEQ_PLAIN,
      SEQ_OVERLONG,
      SEQ_SURROGATE,
      SEQ_NONCHAR,
      SEQ_ABOVE_MAX,
      SEQ_TRUNCATED,
      SEQ_BAD_CONT,
      SEQ_NOISE
   } sequence_kind_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic [7:0]             req_tdata  = 8'h00;
   logic                   req_tlast  = 1'b0;
   logic                   rsp_tready = 1'b0;
   logic                   csr_we     = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index  = REG_REJECT_OVERLONG;
   logic                   csr_wdata  = 1'b0;
   logic                   req_tready;
   logic                   rsp_tvalid;
   logic [23:0]            rsp_tdata;
   logic                   rsp_tuser;
   logic                   rsp_tlast;

   utf8_decode_scoreboard decode_board;
   int unsigned           cycle_count = 0;
   int unsigned           burst_left  = 0;
   int unsigned           hold_left   = 0;
   int unsigned           style_left  = 0;
   bit                    hold_request = 1'b0;
   ready_style_type       ready_style = READY_ALWAYS;
   logic [3:0]            pass_settings[PASS_COUNT];

   // Each entry is {stream_last, in_byte}.
   logic [8:0] opening_bytes[22] = '{
      9'h000, 9'h07F, 9'h0C2, 9'h0A9, 9'h0EF, 9'h0BF, 9'h0BE, 9'h0F4, 9'h090, 9'h080, 9'h080,
      9'h080, 9'h0FF, 9'h0E2, 9'h041, 9'h0C0, 9'h080, 9'h0ED, 9'h0A0, 9'h080, 9'h0F0, 9'h190
   };

   utf8_validating_decoder_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready)
            decode_board.check_word(rsp_tdata[20:0], rsp_tuser, rsp_tlast);
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (style_left == 0) begin
            ready_style = ready_style_type'($urandom_range(0, 3));
            style_left = $urandom_range(20, 80);
         end else begin
            style_left--;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            case (ready_style)
               READY_ALWAYS: rsp_tready <= 1'b1;
               READY_MOSTLY: rsp_tready <= ($urandom_range(0, 9) < 7);
               READY_RARELY: rsp_tready <= ($urandom_range(0, 3) == 0);
               default:      rsp_tready <= ((cycle_count % 5) < 2);
            endcase
         end
      end
   end

   function automatic bit random_last();
      return $urandom_range(0, 39) == 0;
   endfunction

   task automatic send_byte(input logic [7:0] data, input logic last);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            @(negedge clock) req_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      decode_board.note_byte(data, last);
   endtask

   task automatic wait_drained();
      @(negedge clock) req_tvalid <= 1'b0;
      burst_left = 0;
      while (decode_board.outstanding() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index, input logic value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      decode_board.write_register(index, value);
      @(negedge clock) csr_we <= 1'b0;
   endtask

   // Setting bits from the top: overlong, surrogate, out of range, noncharacter.
   task automatic apply_setting(input logic [3:0] setting);
      write_register(REG_REJECT_OVERLONG, setting[3]);
      write_register(REG_REJECT_SURROGATE, setting[2]);
      write_register(REG_REJECT_OUT_OF_RANGE, setting[1]);
      write_register(REG_REJECT_NONCHAR, setting[0]);
   endtask

   task automatic send_encoded(input logic [20:0] value, input int unsigned len,
                               input int unsigned keep, input int unsigned bad_pos,
                               input logic end_last);
      logic [3:0][7:0] enc;
      logic [7:0]      junk;
      int unsigned     i;
      enc = '0;
      case (len)
         1: enc[0] = {1'b0, value[6:0]};
         2: begin
            enc[0] = {3'b110, value[10:6]};
            enc[1] = {2'b10, value[5:0]};
         end
         3: begin
            enc[0] = {4'b1110, value[15:12]};
            enc[1] = {2'b10, value[11:6]};
            enc[2] = {2'b10, value[5:0]};
         end
         default: begin
            enc[0] = {5'b11110, value[20:18]};
            enc[1] = {2'b10, value[17:12]};
            enc[2] = {2'b10, value[11:6]};
            enc[3] = {2'b10, value[5:0]};
         end
      endcase
      if (bad_pos != 0) begin
         junk = 8'($urandom_range(0, 255));
         if (junk[7:6] == 2'b10) junk[6] = 1'b1;
         enc[bad_pos] = junk;
      end
      for (i = 0; i < keep; i++) send_byte(enc[i], (i == keep - 1) ? end_last : random_last());
   endtask

   function automatic logic [20:0] plain_value(input int unsigned len);
      case (len)
         1: return 21'($urandom_range(0, CP_MIN_2BYTE - 1));
         2: return 21'($urandom_range(CP_MIN_2BYTE, CP_MIN_3BYTE - 1));
         3: return 21'($urandom_range(CP_MIN_3BYTE, CP_MIN_4BYTE - 1));
         default: return 21'($urandom_range(CP_MIN_4BYTE, CP_MAX));
      endcase
   endfunction

   task automatic send_random_sequence();
      sequence_kind_type kind;
      int unsigned       pick;
      int unsigned       len;
      logic [20:0]       value;
      pick = $urandom_range(0, 99);
      if (pick < 50) kind = SEQ_PLAIN;
      else if (pick < 58) kind = SEQ_OVERLONG;
      else if (pick < 64) kind = SEQ_SURROGATE;
      else if (pick < 70) kind = SEQ_NONCHAR;
      else if (pick < 76) kind = SEQ_ABOVE_MAX;
      else if (pick < 86) kind = SEQ_TRUNCATED;
      else if (pick < 92) kind = SEQ_BAD_CONT;
      else kind = SEQ_NOISE;
      len = $urandom_range(1, 4);
      value = plain_value(len);
      case (kind)
         SEQ_PLAIN: send_encoded(value, len, len, 0, random_last());
         SEQ_OVERLONG: begin
            len = $urandom_range(2, 4);
            value = plain_value($urandom_range(1, len - 1));
            send_encoded(value, len, len, 0, random_last());
         end
         SEQ_SURROGATE: begin
            value = 21'($urandom_range(CP_SURR_LO, CP_SURR_HI));
            send_encoded(value, 3, 3, 0, random_last());
         end
         SEQ_NONCHAR: begin
            if ($urandom_range(0, 2) == 0) begin
               value = 21'($urandom_range(CP_NONCHAR_LO, CP_NONCHAR_HI));
            end else begin
               value = {5'($urandom_range(0, 16)), 15'h7FFF, 1'($urandom_range(0, 1))};
            end
            send_encoded(value, (value < CP_MIN_4BYTE) ? 3 : 4,
                         (value < CP_MIN_4BYTE) ? 3 : 4, 0, random_last());
         end
         SEQ_ABOVE_MAX: begin
            if ($urandom_range(0, 3) == 0)
               value = {5'($urandom_range(17, 31)), 15'h7FFF, 1'($urandom_range(0, 1))};
            else
               value = 21'($urandom_range(CP_MAX + 1, 21'h1FFFFF));
            send_encoded(value, 4, 4, 0, random_last());
         end
         SEQ_TRUNCATED: begin
            len = $urandom_range(2, 4);
            value = plain_value(len);
            send_encoded(value, len, $urandom_range(1, len - 1), 0,
                         1'($urandom_range(0, 1)));
         end
         SEQ_BAD_CONT: begin
            len = $urandom_range(2, 4);
            value = plain_value(len);
            send_encoded(value, len, len, $urandom_range(1, len - 1), random_last());
         end
         default: send_byte(8'($urandom_range(0, 255)), random_last());
      endcase
   endtask

   initial begin
      int unsigned pass_index;
      int unsigned pass_target;
      decode_board = new();
      pass_settings = '{4'b1111, 4'b0000, 4'b1010, 4'b0101, 4'($urandom_range(0, 15)),
                        4'b1111};
      repeat (5) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      foreach (opening_bytes[i]) send_byte(opening_bytes[i][7:0], opening_bytes[i][8]);
      wait_drained();

      for (pass_index = 0; pass_index < PASS_COUNT; pass_index++) begin
         apply_setting(pass_settings[pass_index]);
         // A long output stall early in the first pass backs the block up into its input.
         if (pass_index == 0) hold_request = 1'b1;
         pass_target = decode_board.bytes_seen + BYTES_PER_PASS;
         while (decode_board.bytes_seen < pass_target) send_random_sequence();
         send_byte(8'($urandom_range(0, 127)), 1'b1);
         wait_drained();
      end

      $display("Decoded %0d bytes into %0d words (%0d malformed) under %0d reject settings.",
               decode_board.bytes_seen, decode_board.words_seen, decode_board.malformed_seen,
               PASS_COUNT);
      $display("Stimulus mixed valid, overlong, surrogate, noncharacter, out-of-range, ",
               "truncated and corrupt sequences with input gaps and output stalls.");
      if (decode_board.mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
src/utf8d_pkg.sv
src/utf8_validating_decoder_unit.sv
dv/utf8_decode_scoreboard_pkg.sv
dv/tb.sv
